// ----- rtl/hpc_pkg.sv -----
`timescale 1ns / 1ps

package hpc_pkg;

  localparam int unsigned DEF_INDEX_BITS    = 16;
  localparam int unsigned DEF_HUE_FRAC_BITS = 16;

  localparam int unsigned MAX_W      = 16;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned Q12_W      = 13;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // 100 * max_iterations fits here
  localparam int unsigned DEN_W  = 23;
  // t1, t2 and their difference in q0.24, up to one
  localparam int unsigned TONE_W = 25;
  localparam int unsigned TONE_FRAC = 24;

  localparam int unsigned CHAN_STAGES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_OFFSET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = 4'd3;

  localparam logic [Q12_W-1:0]   Q12_ONE   = 13'd4096;
  localparam logic [Q12_W-1:0]   Q12_HALF  = 13'd2048;
  localparam logic [MAX_W-1:0]   MAX_ITER_RST = 16'd255;
  localparam logic [OFF_W-1:0]   HUE_OFFSET_RST = 7'd0;
  localparam logic [OFF_W-1:0]   HUNDRED   = 7'd100;
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

  typedef struct packed {
    logic [TONE_W-1:0] t1;
    logic [TONE_W-1:0] d;
  } tone_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

// ----- rtl/hpc_chan.sv -----
`timescale 1ns / 1ps

module hpc_chan #(
  parameter int unsigned HUE_FRAC_BITS = hpc_pkg::DEF_HUE_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  hpc_pkg::tone_t               tone_i,
  input  logic [HUE_FRAC_BITS+2:0]     pos_i,
  output logic [hpc_pkg::COLOR_W-1:0]  color_o
);

  localparam int unsigned FW     = HUE_FRAC_BITS;
  localparam int unsigned POS_W  = FW + 3;
  localparam int unsigned W_W    = FW + 1;
  localparam int unsigned V_W    = hpc_pkg::TONE_W + FW;
  localparam int unsigned PROD_W = V_W + 1;
  localparam int unsigned SHIFT  = hpc_pkg::TONE_FRAC + FW;
  localparam int unsigned SC_W   = V_W + hpc_pkg::COLOR_W;
  localparam int unsigned C_W    = SC_W - SHIFT;

  localparam logic [POS_W-1:0] UNIT   = POS_W'(1) << FW;
  localparam logic [POS_W-1:0] UNIT3  = POS_W'(3) << FW;
  localparam logic [POS_W-1:0] UNIT4  = POS_W'(4) << FW;
  localparam logic [SC_W-1:0]  HALF   = SC_W'(1) << (SHIFT - 1);

  logic [W_W-1:0]    w_d, w_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0] v_sum;
  logic [V_W-1:0]    v_q;
  logic [SC_W-1:0]   sc;
  logic [C_W-1:0]    c;
  logic [hpc_pkg::COLOR_W-1:0] color_q;

  // ramp weight: rising, flat top, falling, floor
  always_comb begin
    if (pos_i < UNIT) begin
      w_d = W_W'(pos_i);
    end else if (pos_i < UNIT3) begin
      w_d = W_W'(UNIT);
    end else if (pos_i < UNIT4) begin
      w_d = W_W'(UNIT4 - pos_i);
    end else begin
      w_d = '0;
    end
  end

  assign prod_d = PROD_W'(tone_i.d) * PROD_W'(w_q);
  assign v_sum  = PROD_W'({tone_i.t1, {FW{1'b0}}}) + prod_q;
  assign sc     = {v_q, {hpc_pkg::COLOR_W{1'b0}}} - SC_W'(v_q) + HALF;
  assign c      = sc[SC_W-1:SHIFT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q     <= w_d;
      prod_q  <= prod_d;
      v_q     <= v_sum[V_W-1:0];
      color_q <= c[C_W-1] ? hpc_pkg::COLOR_MAX : c[hpc_pkg::COLOR_W-1:0];
    end
  end

  assign color_o = color_q;

endmodule

// ----- rtl/hsl_palette_color_top.sv -----
// HSL palette lookup: each request carries a palette index and returns one RGB color
// whose hue is frac(hue_offset/100 + index/max_iterations) of a full turn, with the
// saturation and lightness registers (q0.12, 4096 is one) applied as in the usual
// HSL to RGB conversion and each channel rounded half up to 8 bits. One index is
// taken every clock while the skid register is empty; the hue comes from two restoring
// dividers that resolve one quotient bit per pipeline stage (index modulo
// max_iterations, then the hue fraction). A stalled output holds the whole pipeline
// through a one-entry skid register, so nothing is lost. The user must write
// registers through the config port only while no request is in flight; the block
// itself does not enforce this. Written registers apply to every request taken from
// the next cycle on.
`timescale 1ns / 1ps

module hsl_palette_color_top #(
  parameter int unsigned INDEX_BITS    = hpc_pkg::DEF_INDEX_BITS,
  parameter int unsigned HUE_FRAC_BITS = hpc_pkg::DEF_HUE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [INDEX_BITS-1:0]           index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hpc_pkg::COLOR_W-1:0]     red_o,
  output logic [hpc_pkg::COLOR_W-1:0]     green_o,
  output logic [hpc_pkg::COLOR_W-1:0]     blue_o
);

  localparam int unsigned IB    = INDEX_BITS;
  localparam int unsigned FW    = HUE_FRAC_BITS;
  localparam int unsigned MW    = hpc_pkg::MAX_W;
  localparam int unsigned DW    = hpc_pkg::DEN_W;
  localparam int unsigned SW    = DW + 1;
  localparam int unsigned QW    = hpc_pkg::Q12_W;
  localparam int unsigned LSW   = 2 * QW;
  localparam int unsigned TW    = hpc_pkg::TONE_W;
  localparam int unsigned POS_W = FW + 3;
  localparam int unsigned CS    = hpc_pkg::CHAN_STAGES;

  localparam logic [POS_W:0] UNIT2 = (POS_W+1)'(2) << FW;
  localparam logic [POS_W:0] UNIT4 = (POS_W+1)'(4) << FW;
  localparam logic [POS_W:0] UNIT6 = (POS_W+1)'(6) << FW;

  // config registers
  logic [MW-1:0]                max_iter_q;
  logic [hpc_pkg::OFF_W-1:0]    hue_off_q;
  logic [QW-1:0]                sat_q, light_q;

  // values derived from config
  logic [MW-1:0]                m_eff;
  logic [hpc_pkg::OFF_W-1:0]    off_adj;
  logic [MW-1:0]                m_q;
  logic [DW-1:0]                den_q, offm_q;
  logic [QW-1:0]                cs_q, cl_q;
  logic [LSW-1:0]               ls_q, l12, s12, t2_d, t1_d, dd_d;
  logic [TW-1:0]                t2_q;
  hpc_pkg::tone_t               tone_q;

  // pipeline
  logic                         en;
  logic                         v0_q;
  logic [IB-1:0]                idx_q;
  logic [IB-1:0]                md_v_q;
  logic [MW:0]                  md_sh [IB];
  logic [MW:0]                  md_df [IB];
  logic [MW-1:0]                md_r_d [IB];
  logic [MW-1:0]                md_r_q [IB];
  logic [IB-1:0]                md_x_d [IB];
  logic [IB-1:0]                md_x_q [IB];
  logic                         sum_v_q, rem_v_q;
  logic [SW-1:0]                sum_d, sum_q, rem_df;
  logic [DW-1:0]                rem_q;
  logic [FW-1:0]                fd_v_q;
  logic [SW-1:0]                fd_sh [FW];
  logic [SW-1:0]                fd_df [FW];
  logic                         fd_bit [FW];
  logic [DW-1:0]                fd_r_d [FW];
  logic [DW-1:0]                fd_r_q [FW];
  logic [FW-1:0]                fd_q_d [FW];
  logic [FW-1:0]                fd_q_q [FW];
  logic                         pos_v_q, chp_v_q;
  logic [POS_W-1:0]             pos_q;
  logic [POS_W:0]               pr_sum, pb_sum;
  logic [POS_W-1:0]             pr_q, pg_q, pb_q;
  logic [CS-1:0]                cv_q;
  hpc_pkg::rgb_t                chan_rgb;

  // output register and skid
  logic                         inc_v;
  logic                         out_v_q, skid_v_q;
  hpc_pkg::rgb_t                out_q, skid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= hpc_pkg::MAX_ITER_RST;
      hue_off_q  <= hpc_pkg::HUE_OFFSET_RST;
      sat_q      <= hpc_pkg::Q12_ONE;
      light_q    <= hpc_pkg::Q12_HALF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpc_pkg::REG_MAX_ITER:   max_iter_q <= cfg_data_i[MW-1:0];
        hpc_pkg::REG_HUE_OFFSET: hue_off_q  <= cfg_data_i[hpc_pkg::OFF_W-1:0];
        hpc_pkg::REG_SATURATION: sat_q      <= cfg_data_i[QW-1:0];
        hpc_pkg::REG_LIGHTNESS:  light_q    <= cfg_data_i[QW-1:0];
        default: ;
      endcase
    end
  end

  // zero divisor counts as one, offsets past a full turn fold back
  assign m_eff   = (max_iter_q == '0) ? MW'(1) : max_iter_q;
  assign off_adj = (hue_off_q >= hpc_pkg::HUNDRED) ? hue_off_q - hpc_pkg::HUNDRED : hue_off_q;

  // t2 = l(1+s) or l+s-ls, t1 = 2l-t2, all q0.24
  assign l12  = LSW'({cl_q, 12'b0});
  assign s12  = LSW'({cs_q, 12'b0});
  assign t2_d = (cl_q <= hpc_pkg::Q12_HALF) ? ls_q + l12 : l12 + s12 - ls_q;
  assign t1_d = LSW'({cl_q, 13'b0}) - LSW'(t2_q);
  assign dd_d = LSW'({t2_q, 1'b0}) - LSW'({cl_q, 13'b0});

  always_ff @(posedge clk_i) begin
    m_q       <= m_eff;
    den_q     <= DW'(m_eff) * DW'(hpc_pkg::HUNDRED);
    offm_q    <= DW'(off_adj) * DW'(m_eff);
    cs_q      <= (sat_q > hpc_pkg::Q12_ONE) ? hpc_pkg::Q12_ONE : sat_q;
    cl_q      <= (light_q > hpc_pkg::Q12_ONE) ? hpc_pkg::Q12_ONE : light_q;
    ls_q      <= LSW'(cl_q) * LSW'(cs_q);
    t2_q      <= t2_d[TW-1:0];
    tone_q.t1 <= t1_d[TW-1:0];
    tone_q.d  <= dd_d[TW-1:0];
  end

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // index modulo max_iterations, one bit per stage
  always_comb begin
    md_sh[0]  = {{MW{1'b0}}, idx_q[IB-1]};
    md_x_d[0] = idx_q << 1;
    for (int k = 1; k < IB; k++) begin
      md_sh[k]  = {md_r_q[k-1], md_x_q[k-1][IB-1]};
      md_x_d[k] = md_x_q[k-1] << 1;
    end
    for (int k = 0; k < IB; k++) begin
      md_df[k]  = md_sh[k] - {1'b0, m_q};
      md_r_d[k] = (md_sh[k] >= {1'b0, m_q}) ? md_df[k][MW-1:0] : md_sh[k][MW-1:0];
    end
  end

  // offset term plus 100 * (index mod m) stays below twice the divisor
  assign sum_d  = SW'(offm_q) + SW'(md_r_q[IB-1]) * SW'(hpc_pkg::HUNDRED);
  assign rem_df = sum_q - SW'(den_q);

  // hue fraction (rem << FW) / den, one quotient bit per stage
  always_comb begin
    fd_sh[0] = {rem_q, 1'b0};
    for (int k = 1; k < FW; k++) begin
      fd_sh[k] = {fd_r_q[k-1], 1'b0};
    end
    for (int k = 0; k < FW; k++) begin
      fd_df[k]  = fd_sh[k] - SW'(den_q);
      fd_bit[k] = (fd_sh[k] >= SW'(den_q));
      fd_r_d[k] = fd_bit[k] ? fd_df[k][DW-1:0] : fd_sh[k][DW-1:0];
    end
    fd_q_d[0] = {{(FW-1){1'b0}}, fd_bit[0]};
    for (int k = 1; k < FW; k++) begin
      fd_q_d[k] = {fd_q_q[k-1][FW-2:0], fd_bit[k]};
    end
  end

  // red sits two sextants ahead, blue two behind
  assign pr_sum = {1'b0, pos_q} + UNIT2;
  assign pb_sum = {1'b0, pos_q} + UNIT4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q  <= index_i;
      md_r_q <= md_r_d;
      md_x_q <= md_x_d;
      sum_q  <= sum_d;
      rem_q  <= (sum_q >= SW'(den_q)) ? rem_df[DW-1:0] : sum_q[DW-1:0];
      fd_r_q <= fd_r_d;
      fd_q_q <= fd_q_d;
      pos_q  <= POS_W'({fd_q_q[FW-1], 2'b0}) + POS_W'({fd_q_q[FW-1], 1'b0});
      pr_q   <= (pr_sum >= UNIT6) ? POS_W'(pr_sum - UNIT6) : POS_W'(pr_sum);
      pg_q   <= pos_q;
      pb_q   <= (pb_sum >= UNIT6) ? POS_W'(pb_sum - UNIT6) : POS_W'(pb_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      md_v_q  <= '0;
      sum_v_q <= 1'b0;
      rem_v_q <= 1'b0;
      fd_v_q  <= '0;
      pos_v_q <= 1'b0;
      chp_v_q <= 1'b0;
      cv_q    <= '0;
    end else if (en) begin
      v0_q    <= in_valid_i;
      md_v_q  <= {md_v_q[IB-2:0], v0_q};
      sum_v_q <= md_v_q[IB-1];
      rem_v_q <= sum_v_q;
      fd_v_q  <= {fd_v_q[FW-2:0], rem_v_q};
      pos_v_q <= fd_v_q[FW-1];
      chp_v_q <= pos_v_q;
      cv_q    <= {cv_q[CS-2:0], chp_v_q};
    end
  end

  hpc_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .tone_i  (tone_q),
    .pos_i   (pr_q),
    .color_o (chan_rgb.red)
  );

  hpc_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .tone_i  (tone_q),
    .pos_i   (pg_q),
    .color_o (chan_rgb.green)
  );

  hpc_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .tone_i  (tone_q),
    .pos_i   (pb_q),
    .color_o (chan_rgb.blue)
  );

  assign inc_v = en && cv_q[CS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= inc_v;
      end
    end else if (inc_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : chan_rgb;
    end else if (inc_v) begin
      skid_q <= chan_rgb;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_o       = out_q.red;
  assign green_o     = out_q.green;
  assign blue_o      = out_q.blue;

endmodule

// ----- rtl/hpc_checker.sv -----
`timescale 1ns / 1ps

module hpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [hpc_pkg::COLOR_W-1:0]  red_o,
  input logic [hpc_pkg::COLOR_W-1:0]  green_o,
  input logic [hpc_pkg::COLOR_W-1:0]  blue_o
);

  // a stalled result holds its color
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

  // with the output empty the skid is empty, so requests are taken
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // back pressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without output stall");

  // a pending request sees ready the cycle after the output drains
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input still blocked after output drained");

endmodule

bind hsl_palette_color_top hpc_checker u_hpc_checker (.*);
